/* rtl/core/ccv_pkg.sv */
// ----------------------------------------------------------------------------
// ccv_pkg
// Shared types, widths and codes of the cylinder cluster validator.
// ----------------------------------------------------------------------------
package ccv_pkg;

  localparam int unsigned CoordW   = 16;
  localparam int unsigned RatioW   = 17;
  localparam int unsigned D2W      = 33;  // dx*dx + dy*dy
  localparam int unsigned SqW      = 32;  // one 16x16 product
  localparam int unsigned RadW     = 50;  // d2 << 16, padded to an even width
  localparam int unsigned RootW    = RadW / 2;
  localparam int unsigned NumW     = 40;  // divider dividend / quotient
  localparam int unsigned DenW     = RootW;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned MaxPointsDef = 4096;

  localparam logic [RatioW-1:0] OneQ16 = RatioW'(65536);

  localparam logic [CfgIdxW-1:0] CfgSmallW = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgSmallH = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgLargeW = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgLargeH = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgCap    = 3'd4;

  typedef enum logic [1:0] {
    MulX = 2'd0,
    MulY = 2'd1,
    MulW = 2'd2
  } mul_sel_e;

  typedef enum logic [1:0] {
    DivRad  = 2'd0,
    DivVert = 2'd1,
    DivFrac = 2'd2
  } div_sel_e;

  typedef struct packed {
    logic     load;
    logic     mul_en;
    mul_sel_e mul_sel;
    logic     test;
    logic     sqrt_start;
    logic     div_start;
    div_sel_e div_sel;
    logic     upd_rad;
    logic     upd_vert;
    logic     upd_frac;
    logic     cap;
    logic     emit;
  } ccv_cmd_t;

  typedef struct packed {
    logic outside;
    logic dist_zero;
    logic az_zero;
    logic last;
    logic n_zero;
    logic sqrt_done;
    logic div_done;
  } ccv_sts_t;

endpackage

/* rtl/core/ccv_sqrt.sv */
// ----------------------------------------------------------------------------
// ccv_sqrt
// Digit-by-digit integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module ccv_sqrt import ccv_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [RadW-1:0]  rad_i,
  output logic             done_o,
  output logic [RootW-1:0] root_o
);

  localparam int unsigned CntW = $clog2(RootW + 1);
  localparam int unsigned RemW = RootW + 1;

  logic [RadW-1:0]  rad_q, rad_d;
  logic [RemW-1:0]  rem_q, rem_d;
  logic [RootW-1:0] root_q, root_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             busy_q, busy_d, done_q, done_d;
  logic [RemW+1:0]  rem_sh, trial;

  always_comb begin
    rem_sh = {rem_q, rad_q[RadW-1 -: 2]};
    trial  = {1'b0, root_q, 2'b01};
    rad_d  = rad_q;
    rem_d  = rem_q;
    root_d = root_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rad_d  = rad_i;
      rem_d  = '0;
      root_d = '0;
      cnt_d  = CntW'(RootW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rad_d = {rad_q[RadW-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_d  = RemW'(rem_sh - trial);
        root_d = {root_q[RootW-2:0], 1'b1};
      end else begin
        rem_d  = RemW'(rem_sh);
        root_d = {root_q[RootW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

/* rtl/core/ccv_div.sv */
// ----------------------------------------------------------------------------
// ccv_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ccv_div import ccv_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [NumW-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  output logic            done_o,
  output logic [NumW-1:0] quo_o
);

  localparam int unsigned CntW = $clog2(NumW + 1);

  logic [NumW-1:0] quo_q, quo_d;
  logic [DenW-1:0] den_q, den_d, rem_q, rem_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d, done_q, done_d;
  logic [DenW:0]   rem_sh;

  always_comb begin
    rem_sh = {rem_q, quo_q[NumW-1]};
    quo_d  = quo_q;
    den_d  = den_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      quo_d  = num_i;
      den_d  = den_i;
      rem_d  = '0;
      cnt_d  = CntW'(NumW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (rem_sh >= {1'b0, den_q}) begin
        rem_d = DenW'(rem_sh - {1'b0, den_q});
        quo_d = {quo_q[NumW-2:0], 1'b1};
      end else begin
        rem_d = DenW'(rem_sh);
        quo_d = {quo_q[NumW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    den_q <= den_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

/* rtl/core/ccv_datapath.sv */
// ----------------------------------------------------------------------------
// ccv_datapath
// Offsets, shared multiplier, cylinder test, ratio and count registers.
// ----------------------------------------------------------------------------
module ccv_datapath import ccv_pkg::*; #(
  parameter int unsigned MAX_POINTS = MaxPointsDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  ccv_cmd_t                 cmd_i,
  output ccv_sts_t                 sts_o,
  input  logic                     cfg_we_i,
  input  logic [CfgIdxW-1:0]       cfg_index_i,
  input  logic [RatioW-1:0]        cfg_data_i,
  input  logic signed [CoordW-1:0] point_x_i,
  input  logic signed [CoordW-1:0] point_y_i,
  input  logic signed [CoordW-1:0] point_z_i,
  input  logic signed [CoordW-1:0] center_x_i,
  input  logic signed [CoordW-1:0] center_y_i,
  input  logic signed [CoordW-1:0] center_z_i,
  input  logic                     is_large_cone_i,
  input  logic                     last_point_i,
  output logic [RatioW-1:0]        radial_ratio_o,
  output logic [RatioW-1:0]        vertical_ratio_o,
  output logic [RatioW-1:0]        inside_fraction_o
);

  localparam int unsigned CntW = $clog2(MAX_POINTS + 1);

  logic [CoordW-1:0] sw_q, sh_q, lw_q, lh_q;
  logic [RatioW-1:0] cap_q;

  logic [CoordW-1:0] ax_q, ay_q, az_q, w_q, h_q;
  logic              last_q;
  logic [D2W-1:0]    d2_q;
  logic [SqW-1:0]    ww_q;
  logic              outside_q;
  logic [RatioW-1:0] min_rad_q, min_rad_d, min_vert_q, min_vert_d;
  logic [CntW-1:0]   seen_q, outside_cnt_q;
  logic [RatioW-1:0] rad_out_q, vert_out_q, frac_out_q, frac_q;

  logic signed [CoordW:0] dx, dy, dz;
  logic [CoordW-1:0]      mul_a;
  logic [SqW-1:0]         prod;
  logic                   outside_now, counting;
  logic [CntW-1:0]        inside_cnt;

  logic            sqrt_done, div_done;
  logic [RootW-1:0] root_dist;
  logic [NumW-1:0]  div_num, quo;
  logic [DenW-1:0]  div_den;

  function automatic logic [CoordW-1:0] abs17(input logic signed [CoordW:0] v);
    logic [CoordW:0] n;
    n = v[CoordW] ? (~v + 1'b1) : v;
    return n[CoordW-1:0];
  endfunction

  assign dx = {point_x_i[CoordW-1], point_x_i} - {center_x_i[CoordW-1], center_x_i};
  assign dy = {point_y_i[CoordW-1], point_y_i} - {center_y_i[CoordW-1], center_y_i};
  assign dz = {point_z_i[CoordW-1], point_z_i} - {center_z_i[CoordW-1], center_z_i};

  always_comb begin
    unique case (cmd_i.mul_sel)
      MulX:    mul_a = ax_q;
      MulY:    mul_a = ay_q;
      MulW:    mul_a = w_q;
      default: mul_a = w_q;
    endcase
  end
  assign prod = mul_a * mul_a;

  assign outside_now = ({d2_q, 2'b00} > {3'b000, ww_q}) ||
                       ({az_q, 1'b0} > {1'b0, h_q});
  assign counting    = seen_q < CntW'(MAX_POINTS);
  assign inside_cnt  = seen_q - outside_cnt_q;

  always_comb begin
    unique case (cmd_i.div_sel)
      DivRad: begin
        div_num = NumW'({w_q, 23'd0});
        div_den = root_dist;
      end
      DivVert: begin
        div_num = NumW'({h_q, 15'd0});
        div_den = DenW'(az_q);
      end
      default: begin
        div_num = NumW'({inside_cnt, 16'd0});
        div_den = DenW'(seen_q);
      end
    endcase
  end

  ccv_sqrt u_sqrt (
    .clk_i,
    .rst_ni,
    .start_i (cmd_i.sqrt_start),
    .rad_i   (RadW'({d2_q, 16'd0})),
    .done_o  (sqrt_done),
    .root_o  (root_dist)
  );

  ccv_div u_div (
    .clk_i,
    .rst_ni,
    .start_i (cmd_i.div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  // ratio update; the cap is applied after every point
  always_comb begin
    min_rad_d  = min_rad_q;
    min_vert_d = min_vert_q;
    if (cmd_i.test && !outside_now) begin
      min_rad_d  = OneQ16;
      min_vert_d = OneQ16;
    end
    if (cmd_i.upd_rad && (quo < NumW'(min_rad_q))) min_rad_d = RatioW'(quo);
    if (cmd_i.upd_vert && (quo < NumW'(min_vert_q))) min_vert_d = RatioW'(quo);
    if (cmd_i.cap) begin
      if (min_rad_q < cap_q) min_rad_d = '0;
      if (min_vert_q < cap_q) min_vert_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sw_q          <= CoordW'(228);
      sh_q          <= CoordW'(325);
      lw_q          <= CoordW'(285);
      lh_q          <= CoordW'(505);
      cap_q         <= '0;
      min_rad_q     <= OneQ16;
      min_vert_q    <= OneQ16;
      seen_q        <= '0;
      outside_cnt_q <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CfgSmallW: sw_q  <= cfg_data_i[CoordW-1:0];
          CfgSmallH: sh_q  <= cfg_data_i[CoordW-1:0];
          CfgLargeW: lw_q  <= cfg_data_i[CoordW-1:0];
          CfgLargeH: lh_q  <= cfg_data_i[CoordW-1:0];
          CfgCap:    cap_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.emit) begin
        min_rad_q     <= OneQ16;
        min_vert_q    <= OneQ16;
        seen_q        <= '0;
        outside_cnt_q <= '0;
      end else begin
        min_rad_q  <= min_rad_d;
        min_vert_q <= min_vert_d;
        if (cmd_i.test && counting) begin
          seen_q <= seen_q + 1'b1;
          if (outside_now) outside_cnt_q <= outside_cnt_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      ax_q   <= abs17(dx);
      ay_q   <= abs17(dy);
      az_q   <= abs17(dz);
      w_q    <= is_large_cone_i ? lw_q : sw_q;
      h_q    <= is_large_cone_i ? lh_q : sh_q;
      last_q <= last_point_i;
    end
    if (cmd_i.mul_en) begin
      unique case (cmd_i.mul_sel)
        MulX:    d2_q <= D2W'(prod);
        MulY:    d2_q <= d2_q + D2W'(prod);
        default: ww_q <= prod;
      endcase
    end
    if (cmd_i.test) outside_q <= outside_now;
    if (cmd_i.cap) frac_q <= OneQ16;
    if (cmd_i.upd_frac) frac_q <= RatioW'(quo);
    if (cmd_i.emit) begin
      rad_out_q  <= min_rad_q;
      vert_out_q <= min_vert_q;
      frac_out_q <= frac_q;
    end
  end

  assign sts_o.outside   = outside_q;
  assign sts_o.dist_zero = (root_dist == '0);
  assign sts_o.az_zero   = (az_q == '0);
  assign sts_o.last      = last_q;
  assign sts_o.n_zero    = (seen_q == '0);
  assign sts_o.sqrt_done = sqrt_done;
  assign sts_o.div_done  = div_done;

  assign radial_ratio_o    = rad_out_q;
  assign vertical_ratio_o  = vert_out_q;
  assign inside_fraction_o = frac_out_q;

endmodule

/* rtl/core/ccv_ctrl.sv */
// ----------------------------------------------------------------------------
// ccv_ctrl
// Sequencer for one point: squares, test, root, divisions, result beat.
// ----------------------------------------------------------------------------
module ccv_ctrl import ccv_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  input  ccv_sts_t sts_i,
  output ccv_cmd_t cmd_o
);

  localparam logic [3:0] SIdle  = 4'd0;
  localparam logic [3:0] SSqX   = 4'd1;
  localparam logic [3:0] SSqY   = 4'd2;
  localparam logic [3:0] SSqW   = 4'd3;
  localparam logic [3:0] STest  = 4'd4;
  localparam logic [3:0] SBr    = 4'd5;
  localparam logic [3:0] SSqrt  = 4'd6;
  localparam logic [3:0] SDivR  = 4'd7;
  localparam logic [3:0] SVert  = 4'd8;
  localparam logic [3:0] SDivV  = 4'd9;
  localparam logic [3:0] SCap   = 4'd10;
  localparam logic [3:0] SFrac  = 4'd11;
  localparam logic [3:0] SDivF  = 4'd12;
  localparam logic [3:0] SEmit  = 4'd13;

  logic [3:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != SIdle);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      SIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = SSqX;
        end
      end
      SSqX: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MulX;
        state_d       = SSqY;
      end
      SSqY: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MulY;
        state_d       = SSqW;
      end
      SSqW: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MulW;
        state_d       = STest;
      end
      STest: begin
        cmd_o.test = 1'b1;
        state_d    = SBr;
      end
      SBr: begin
        if (sts_i.outside) begin
          cmd_o.sqrt_start = 1'b1;
          state_d          = SSqrt;
        end else begin
          state_d = SCap;
        end
      end
      SSqrt: begin
        cmd_o.div_sel = DivRad;
        if (sts_i.sqrt_done) begin
          if (sts_i.dist_zero) begin
            state_d = SVert;
          end else begin
            cmd_o.div_start = 1'b1;
            state_d         = SDivR;
          end
        end
      end
      SDivR: begin
        if (sts_i.div_done) begin
          cmd_o.upd_rad = 1'b1;
          state_d       = SVert;
        end
      end
      SVert: begin
        cmd_o.div_sel = DivVert;
        if (sts_i.az_zero) begin
          state_d = SCap;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d         = SDivV;
        end
      end
      SDivV: begin
        if (sts_i.div_done) begin
          cmd_o.upd_vert = 1'b1;
          state_d        = SCap;
        end
      end
      SCap: begin
        cmd_o.cap = 1'b1;
        state_d   = sts_i.last ? SFrac : SIdle;
      end
      SFrac: begin
        cmd_o.div_sel = DivFrac;
        if (sts_i.n_zero) begin
          state_d = SEmit;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d         = SDivF;
        end
      end
      SDivF: begin
        if (sts_i.div_done) begin
          cmd_o.upd_frac = 1'b1;
          state_d        = SEmit;
        end
      end
      SEmit: begin
        if (out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;
    if (cmd_o.emit) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

/* rtl/core/cylinder_cluster_validator.sv */
// ----------------------------------------------------------------------------
// cylinder_cluster_validator
// Checks the points of a cone cluster against a bounding cylinder.
// ----------------------------------------------------------------------------
// One point is taken at a time; the input stalls until that point is done. A
// point inside the cylinder passes the accept state, three squarings on one
// shared multiplier, the test, the branch and the cap before the next accept.
// A point outside adds a bit-serial square root, up to two passes of the
// bit-serial divider and a state between them. The last point of a cluster
// adds a state to set up the inside fraction, a divider pass and a state to
// load the result register, more while an earlier result still waits; the
// next point may be accepted while that result still waits to be taken.
module cylinder_cluster_validator import ccv_pkg::*; #(
  parameter int unsigned MAX_POINTS = MaxPointsDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CfgIdxW-1:0]       cfg_index_i,
  input  logic [RatioW-1:0]        cfg_data_i,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic signed [CoordW-1:0] point_x_i,
  input  logic signed [CoordW-1:0] point_y_i,
  input  logic signed [CoordW-1:0] point_z_i,
  input  logic signed [CoordW-1:0] center_x_i,
  input  logic signed [CoordW-1:0] center_y_i,
  input  logic signed [CoordW-1:0] center_z_i,
  input  logic                     is_large_cone_i,
  input  logic                     last_point_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [RatioW-1:0]        radial_ratio_o,
  output logic [RatioW-1:0]        vertical_ratio_o,
  output logic [RatioW-1:0]        inside_fraction_o
);

  ccv_cmd_t cmd;
  ccv_sts_t sts;

  assign cfg_ready_o = 1'b1;

  ccv_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .out_valid_o,
    .out_stall_i,
    .sts_i (sts),
    .cmd_o (cmd)
  );

  ccv_datapath #(
    .MAX_POINTS (MAX_POINTS)
  ) u_datapath (
    .clk_i,
    .rst_ni,
    .cmd_i       (cmd),
    .sts_o       (sts),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i,
    .cfg_data_i,
    .point_x_i,
    .point_y_i,
    .point_z_i,
    .center_x_i,
    .center_y_i,
    .center_z_i,
    .is_large_cone_i,
    .last_point_i,
    .radial_ratio_o,
    .vertical_ratio_o,
    .inside_fraction_o
  );

endmodule

/* tb/sv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the cylinder cluster validator: directed cluster
// table, then random clusters checked against a behavioral predictor.
// ----------------------------------------------------------------------------
module tb_top;
  import ccv_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MaxPts   = 4096;
  localparam int unsigned Watchdog = 20000;
  localparam int unsigned Drain    = 300;
  localparam int unsigned HoldLen  = 3000;

  typedef struct {
    logic signed [CoordW-1:0] px, py, pz, cx, cy, cz;
    logic big, last;
  } point_t;

  typedef struct {
    logic [RatioW-1:0] rad, vert, frac;
  } verdict_t;

  typedef struct {
    point_t pt;
    logic   chk;   // typed-in expectation follows
    verdict_t v;
  } row_t;

  logic clk, rst_n;
  logic cfg_valid, cfg_ready;
  logic [CfgIdxW-1:0] cfg_index;
  logic [RatioW-1:0] cfg_data;
  logic in_valid, in_stall;
  logic signed [CoordW-1:0] px, py, pz, cx, cy, cz;
  logic big_cone, last;
  logic out_valid, out_stall;
  logic [RatioW-1:0] rad_o, vert_o, frac_o;

  cylinder_cluster_validator DUT (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .point_x_i(px), .point_y_i(py), .point_z_i(pz),
    .center_x_i(cx), .center_y_i(cy), .center_z_i(cz),
    .is_large_cone_i(big_cone), .last_point_i(last),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .radial_ratio_o(rad_o), .vertical_ratio_o(vert_o), .inside_fraction_o(frac_o)
  );

  // predictor state
  logic [15:0] sw_q = 16'd228, sh_q = 16'd325, lw_q = 16'd285, lh_q = 16'd505;
  logic [16:0] cap_q = '0;
  logic [16:0] min_rad = OneQ16, min_vert = OneQ16;
  int unsigned outside_n = 0, seen_n = 0;

  verdict_t expected_q[$];
  bit failed = 0;
  int unsigned hold_left = 0;  // long receiver hold-off, in cycles
  bit held = 0;
  bit idle_on = 1;
  int unsigned quiet = 0;

  function automatic logic [63:0] isqrt(logic [63:0] v);
    logic [63:0] rem, root, b;
    rem = v; root = 0; b = 64'd1 << 62;
    while (b > rem) b = b >> 2;
    while (b != 0) begin
      if (rem >= root + b) begin
        rem = rem - (root + b);
        root = (root >> 1) + b;
      end else begin
        root = root >> 1;
      end
      b = b >> 2;
    end
    return root;
  endfunction

  task automatic predict_point(point_t p);
    longint dx, dy, dz;
    logic [63:0] ax, ay, az, d2, w, h, dxy, r;
    bit counting;
    verdict_t v;
    dx = longint'(p.px) - longint'(p.cx);
    dy = longint'(p.py) - longint'(p.cy);
    dz = longint'(p.pz) - longint'(p.cz);
    ax = dx < 0 ? -dx : dx;
    ay = dy < 0 ? -dy : dy;
    az = dz < 0 ? -dz : dz;
    d2 = ax * ax + ay * ay;
    w = p.big ? lw_q : sw_q;
    h = p.big ? lh_q : sh_q;
    counting = seen_n < MaxPts;
    if (counting) seen_n++;
    if (4 * d2 > w * w || 2 * az > h) begin
      dxy = isqrt(d2 << 16);
      if (counting) outside_n++;
      if (dxy != 0) begin
        r = (w << 23) / dxy;
        if (r < min_rad) min_rad = r[16:0];
      end
      if (az != 0) begin
        r = (h << 15) / az;
        if (r < min_vert) min_vert = r[16:0];
      end
    end else begin
      min_rad = OneQ16;
      min_vert = OneQ16;
    end
    if (min_rad < cap_q) min_rad = 0;
    if (min_vert < cap_q) min_vert = 0;
    if (p.last) begin
      v.rad = min_rad;
      v.vert = min_vert;
      r = seen_n != 0 ? ((64'(seen_n - outside_n)) << 16) / seen_n : 64'(OneQ16);
      v.frac = r[16:0];
      expected_q.push_back(v);
      min_rad = OneQ16; min_vert = OneQ16; outside_n = 0; seen_n = 0;
    end
  endtask

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // result checker and receiver stall
  always @(posedge clk) begin
    verdict_t e;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result rad=%0d vert=%0d frac=%0d",
                   $time, rad_o, vert_o, frac_o);
          failed = 1;
        end else begin
          e = expected_q.pop_front();
          if (rad_o !== e.rad) begin
            $display("%0t: radial_ratio exp %0d got %0d", $time, e.rad, rad_o);
            failed = 1;
          end
          if (vert_o !== e.vert) begin
            $display("%0t: vertical_ratio exp %0d got %0d", $time, e.vert, vert_o);
            failed = 1;
          end
          if (frac_o !== e.frac) begin
            $display("%0t: inside_fraction exp %0d got %0d", $time, e.frac, frac_o);
            failed = 1;
          end
        end
      end
      out_stall <= (hold_left != 0) || (idle_on && $urandom_range(99) < 37);
      if (hold_left != 0) hold_left--;
    end
  end

  // watchdog on accepted beats
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet = 0;
    else
      quiet++;
    if (quiet >= Watchdog) begin
      $display("cylinder_cluster_validator test failed");
      $finish;
    end
  end

  task automatic cfg_write(logic [CfgIdxW-1:0] idx, logic [RatioW-1:0] val);
    cfg_valid <= 1; cfg_index <= idx; cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    case (idx)
      CfgSmallW: sw_q = val[15:0];
      CfgSmallH: sh_q = val[15:0];
      CfgLargeW: lw_q = val[15:0];
      CfgLargeH: lh_q = val[15:0];
      CfgCap:    cap_q = val;
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    in_valid <= 0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (Drain) @(posedge clk);
  endtask

  task automatic send_point(point_t p);
    while (idle_on && $urandom_range(99) < 37) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    px <= p.px; py <= p.py; pz <= p.pz; cx <= p.cx; cy <= p.cy; cz <= p.cz;
    big_cone <= p.big; last <= p.last;
    do @(posedge clk); while (in_stall);
    predict_point(p);
  endtask

  function automatic point_t rand_point(bit lg, bit ls, int spread);
    point_t p;
    p.cx = $urandom; p.cy = $urandom; p.cz = $urandom;
    p.px = p.cx + $signed($urandom_range(2 * spread)) - spread;
    p.py = p.cy + $signed($urandom_range(2 * spread)) - spread;
    p.pz = p.cz + $signed($urandom_range(2 * spread)) - spread;
    p.big = lg; p.last = ls;
    return p;
  endfunction

  function automatic point_t mk(int x, int y, int z, int cx_, int cy_, int cz_,
                                bit lg, bit ls);
    point_t p;
    p.px = x; p.py = y; p.pz = z; p.cx = cx_; p.cy = cy_; p.cz = cz_;
    p.big = lg; p.last = ls;
    return p;
  endfunction

  initial begin
    row_t dir[$];
    row_t rw;
    point_t p;
    verdict_t v;
    int n, cl, sp;
    bit lg;
    rst_n = 0; cfg_valid = 0; cfg_index = '0; cfg_data = '0;
    in_valid = 0; px = 0; py = 0; pz = 0; cx = 0; cy = 0; cz = 0;
    big_cone = 0; last = 0; out_stall = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // single inside point after reset: ratios 1.0, fraction 1.0
    rw.pt = mk(0, 0, 0, 0, 0, 0, 0, 1); rw.chk = 1;
    rw.v.rad = OneQ16; rw.v.vert = OneQ16; rw.v.frac = OneQ16;
    dir.push_back(rw);
    rw.chk = 0;
    // extremes of coordinates, outside
    rw.pt = mk(32767, 32767, 32767, -32768, -32768, -32768, 0, 0); dir.push_back(rw);
    rw.pt = mk(-32768, -32768, -32768, 32767, 32767, 32767, 1, 1); dir.push_back(rw);
    // zero horizontal distance, outside by height
    rw.pt = mk(5, 5, 1000, 5, 5, 0, 0, 1); dir.push_back(rw);
    // zero vertical distance, outside by width
    rw.pt = mk(1000, 0, 7, 0, 0, 7, 1, 0); dir.push_back(rw);
    // large inside large cylinder but outside small one
    rw.pt = mk(130, 0, 200, 0, 0, 0, 1, 1); dir.push_back(rw);
    rw.pt = mk(130, 0, 200, 0, 0, 0, 0, 1); dir.push_back(rw);
    // outside then inside resets, then outside again
    rw.pt = mk(400, 300, 500, 0, 0, 0, 0, 0); dir.push_back(rw);
    rw.pt = mk(10, -10, 3, 0, 0, 0, 0, 0); dir.push_back(rw);
    rw.pt = mk(-300, 200, -400, 0, 0, 0, 1, 1); dir.push_back(rw);
    // boundary: exactly on edge is inside
    rw.pt = mk(114, 0, 162, 0, 0, 0, 0, 0); dir.push_back(rw);
    rw.pt = mk(115, 0, 163, 0, 0, 0, 0, 1); dir.push_back(rw);

    foreach (dir[i]) begin
      send_point(dir[i].pt);
      if (dir[i].chk) begin
        // typed value replaces the predicted one at the tail
        v = expected_q.pop_back();
        expected_q.push_back(dir[i].v);
      end
    end
    wait_idle();

    // cap above one zeroes all ratios, extreme sizes
    cfg_write(CfgCap, 17'h1FFFF);
    cfg_write(CfgSmallW, 16'hFFFF);
    cfg_write(CfgSmallH, 16'hFFFF);
    cfg_write(CfgLargeW, 16'h0000);
    cfg_write(CfgLargeH, 16'h0000);
    cfg_write(3'd7, 17'h1ABCD);   // unmapped index, ignored
    send_point(mk(0, 0, 0, 0, 0, 0, 0, 1));
    send_point(mk(1, 0, 0, 0, 0, 0, 1, 0));
    send_point(mk(0, 0, 0, 0, 0, 0, 1, 1));
    wait_idle();

    // random phases over several register settings
    for (int ph = 0; ph < 5; ph++) begin
      cfg_write(CfgSmallW, ph == 4 ? 16'hFFFF : $urandom_range(50, 600));
      cfg_write(CfgSmallH, $urandom_range(50, 800));
      cfg_write(CfgLargeW, ph == 4 ? 16'h0 : $urandom_range(50, 900));
      cfg_write(CfgLargeH, $urandom_range(50, 1200));
      cfg_write(CfgCap, ph == 4 ? 17'd65536 : (ph % 2 ? $urandom_range(65536) : 17'd0));
      n = 0;
      while (n < 230) begin
        cl = $urandom_range(1, 8);
        lg = $urandom_range(1);
        sp = $urandom_range(99) < 15 ? 32767 : $urandom_range(20, 700);
        if (ph == 2 && n >= 60 && !held) begin
          hold_left = HoldLen;
          held = 1;
        end
        for (int k = 0; k < cl; k++) begin
          send_point(rand_point(lg, k == cl - 1, sp));
          n++;
        end
        if (ph == 1 && n > 100 && n < 110) begin
          in_valid <= 0;
          while (expected_q.size() != 0) @(posedge clk);
        end
        if (ph == 3 && n < 120) idle_on = 0;
        else idle_on = 1;
      end
      in_valid <= 0;
      wait_idle();
    end

    if (!failed && expected_q.size() == 0)
      $display("cylinder_cluster_validator test passed");
    else
      $display("cylinder_cluster_validator test failed");
    $finish;
  end

endmodule
